>>> rtl/rc_pulse_throttle_decoder_top_assert.svh
// Assertion macros for the throttle decoder.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef RC_PULSE_THROTTLE_DECODER_TOP_ASSERT_SVH
`define RC_PULSE_THROTTLE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCPTD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCPTD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rcptd_pkg.sv
// Shared types and constants of the throttle decoder.
// No dependencies; used by the result channel interface and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rcptd_pkg;

	localparam int COUNT_W      = 15;
	localparam int DZ_W         = 7;
	localparam int RLIM_W       = 7;
	localparam int THR_W        = 8;
	localparam int GEAR_W       = 2;
	localparam int FILL_W       = 7;
	localparam int MAG_W        = 7;
	localparam int NUM_W        = 23;
	localparam int QUO_W        = 8;
	localparam int STEP_W       = 3;
	localparam int PADDR_W      = 5;
	localparam int PDATA_W      = 32;

	localparam int GAUGE_WIDTH_DEF = 96;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [COUNT_W-1:0] PULSE_MIN_RST = 15'd1000;
	localparam logic [COUNT_W-1:0] PULSE_MAX_RST = 15'd2000;
	localparam logic [DZ_W-1:0]    DEADZONE_RST  = 7'd10;
	localparam logic [RLIM_W-1:0]  REV_LIMIT_RST = 7'd96;
	localparam logic [COUNT_W-1:0] TIMEOUT_RST   = 15'd25000;

	localparam logic [THR_W-1:0]  THR_OFFSET   = 8'd100;
	localparam logic [NUM_W-1:0]  FILL_DSH     = NUM_W'(100 * (2 ** (QUO_W - 1)));
	localparam logic [STEP_W-1:0] STEP_LAST    = STEP_W'(QUO_W - 1);

	localparam logic [GEAR_W-1:0] GR_NEUTRAL  = 2'd0;
	localparam logic [GEAR_W-1:0] GR_FORWARD  = 2'd1;
	localparam logic [GEAR_W-1:0] GR_BACKWARD = 2'd2;

	typedef enum logic [2:0] {
		REG_PULSE_MIN = 3'd0,
		REG_PULSE_MAX = 3'd1,
		REG_DEADZONE  = 3'd2,
		REG_REV_LIMIT = 3'd3,
		REG_TIMEOUT   = 3'd4
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_MAP    = 5'b00010,
		S_DIVIDE = 5'b00100,
		S_GAUGE  = 5'b01000,
		S_WRITE  = 5'b10000
	} state_t;

endpackage

`default_nettype wire

>>> rtl/rcptd_in_if.sv
// Input channel of the throttle decoder: one pin sample per transfer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rcptd_in_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

>>> rtl/rcptd_out_if.sv
// Result channel of the throttle decoder: one decoded result per transfer.
// Depends on rcptd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rcptd_out_if import rcptd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [THR_W-1:0]  throttle;
	logic [GEAR_W-1:0]        gear;
	logic [FILL_W-1:0]        gauge_fill;
	logic                     changed;
	logic                     signal_present;

	modport source (output valid, output throttle, output gear, output gauge_fill,
		output changed, output signal_present, input ready);
	modport sink (input valid, input throttle, input gear, input gauge_fill,
		input changed, input signal_present, output ready);
endinterface

`default_nettype wire

>>> rtl/rc_pulse_throttle_decoder_top.sv
// Throttle decoder for an RC servo pulse train.
// The sample channel carries one pin sample per transfer, nominally one per microsecond tick.
// Each high pulse is measured in samples; when it ends, or when the timeout register's count
// of samples passes without a complete pulse, one result goes out on the result channel.
// A sample that yields no result leaves the block idle, so it stays ready for the next
// sample. A completed pulse is worked through in order: the sample is taken, the width is
// clamped, the throttle division runs, gear and gauge scaling are worked out, the gauge
// division runs and the output register is loaded; only then can the next sample be taken.
// A width clamped to either limit skips the throttle division.
// Both divisions run through one shared restoring divider that retires a single
// quotient bit per cycle.
// Results sit in an output register; while a result waits for the receiver, further
// samples are still taken, and only a new result stalls (in its write cycle) until
// the register is free. Nothing is ever dropped.
// Reset (arst_n low) loads the register defaults, clears the pulse and timeout
// counters, the previous pin level and the last throttle, and empties the output.
// The user writes configuration over the APB port at byte address 4*index only while the
// block is idle; the block does not enforce this. Reads return the stored register value.
// Depends on rcptd_pkg, rcptd_in_if, rcptd_out_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module rc_pulse_throttle_decoder_top
	import rcptd_pkg::*;
#(
	parameter int GAUGE_WIDTH = GAUGE_WIDTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	rcptd_in_if.sink           sample,
	rcptd_out_if.source        result,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [PADDR_W-1:0]  paddr,
	input  wire [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	`include "rc_pulse_throttle_decoder_top_assert.svh"

	// The span of the gauge needs enough bits to hold GAUGE_WIDTH itself.
	localparam int SPAN_W = $clog2(GAUGE_WIDTH + 1);
	localparam int PROD_W = MAG_W + SPAN_W;
	// The reverse limit is compared against the gauge width at the wider of the two.
	localparam int CMP_W  = (SPAN_W > RLIM_W) ? SPAN_W : RLIM_W;

	// Configuration registers.
	logic [COUNT_W-1:0] pulse_min_q;
	logic [COUNT_W-1:0] pulse_max_q;
	logic [DZ_W-1:0]    deadzone_q;
	logic [RLIM_W-1:0]  rev_limit_q;
	logic [COUNT_W-1:0] timeout_q;

	// Pulse measurement state.
	logic               prev_level_q;
	logic [COUNT_W-1:0] high_count_q;
	logic [COUNT_W-1:0] wait_count_q;
	logic signed [THR_W-1:0] last_thr_q;

	// Sequencer and working registers.
	state_t             state_q;
	logic [COUNT_W-1:0] width_q;
	logic signed [THR_W-1:0] thr_q;
	logic [GEAR_W-1:0]  gear_q;
	logic [FILL_W-1:0]  fill_q;
	logic               chg_q;
	logic               present_q;
	logic               phase_thr_q;

	// Shared restoring divider.
	logic [NUM_W-1:0]   rem_q;
	logic [NUM_W-1:0]   dsh_q;
	logic [QUO_W-1:0]   quo_q;
	logic [STEP_W-1:0]  step_q;

	// Output register.
	logic               out_valid_q;
	logic signed [THR_W-1:0] out_thr_q;
	logic [GEAR_W-1:0]  out_gear_q;
	logic [FILL_W-1:0]  out_fill_q;
	logic               out_chg_q;
	logic               out_present_q;

	logic               sample_take;
	logic               cfg_write;
	reg_idx_t           cfg_idx;

	// ------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; reads are
	// served straight from the registers.
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q <= PULSE_MIN_RST;
			pulse_max_q <= PULSE_MAX_RST;
			deadzone_q  <= DEADZONE_RST;
			rev_limit_q <= REV_LIMIT_RST;
			timeout_q   <= TIMEOUT_RST;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_PULSE_MIN: pulse_min_q <= pwdata[COUNT_W-1:0];
				REG_PULSE_MAX: pulse_max_q <= pwdata[COUNT_W-1:0];
				REG_DEADZONE:  deadzone_q  <= pwdata[DZ_W-1:0];
				REG_REV_LIMIT: rev_limit_q <= pwdata[RLIM_W-1:0];
				REG_TIMEOUT:   timeout_q   <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PULSE_MIN: prdata = PDATA_W'(pulse_min_q);
			REG_PULSE_MAX: prdata = PDATA_W'(pulse_max_q);
			REG_DEADZONE:  prdata = PDATA_W'(deadzone_q);
			REG_REV_LIMIT: prdata = PDATA_W'(rev_limit_q);
			REG_TIMEOUT:   prdata = PDATA_W'(timeout_q);
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pulse measurement on each accepted sample. A rising edge (or a high
	// pin on the very first sample) starts a count of one; the count
	// saturates. A falling edge with a live count completes the pulse.
	// ------------------------------------------------------------------
	logic               pulse_done;
	logic [COUNT_W-1:0] high_next;
	logic [COUNT_W-1:0] wait_inc;
	logic               timeout_hit;

	always_comb begin
		high_next  = high_count_q;
		pulse_done = 1'b0;
		if (sample.pin_level) begin
			if (!prev_level_q) begin
				high_next = COUNT_W'(1);
			end else if (high_count_q != '0 && high_count_q != COUNT_MAX) begin
				high_next = high_count_q + COUNT_W'(1);
			end
		end else if (prev_level_q && high_count_q != '0) begin
			pulse_done = 1'b1;
			high_next  = '0;
		end
		wait_inc    = wait_count_q + COUNT_W'(wait_count_q != COUNT_MAX);
		// A timeout register of zero behaves like one, as wait_inc is never zero.
		timeout_hit = !pulse_done && (wait_inc >= timeout_q);
	end

	assign sample.ready = (state_q == S_IDLE);
	assign sample_take  = sample.valid && sample.ready;

	// ------------------------------------------------------------------
	// Clamp and division set-up, gear and gauge set-up, divider step.
	// ------------------------------------------------------------------
	logic [COUNT_W-1:0] width_off;
	logic [COUNT_W-1:0] pulse_range;
	logic [NUM_W-1:0]   thr_num;
	logic               at_min;
	logic               at_max;

	// Offset times 200, built as x*128 + x*64 + x*8.
	assign width_off   = width_q - pulse_min_q;
	assign pulse_range = pulse_max_q - pulse_min_q;
	assign thr_num     = NUM_W'({width_off, 7'b0}) + NUM_W'({width_off, 6'b0})
		+ NUM_W'({width_off, 3'b0});
	assign at_min      = (width_q <= pulse_min_q);
	assign at_max      = (width_q >= pulse_max_q);

	logic signed [THR_W:0] thr_ext;
	logic signed [THR_W:0] dz_ext;
	logic                  is_drive;
	logic                  is_reverse;
	logic [MAG_W-1:0]      thr_mag;
	logic [CMP_W-1:0]      rlim_ext;
	logic [SPAN_W-1:0]     span;
	logic [SPAN_W-1:0]     span_m1;
	logic [PROD_W-1:0]     fill_num;

	assign thr_ext    = {thr_q[THR_W-1], thr_q};
	assign dz_ext     = $signed({2'b00, deadzone_q});
	assign is_drive   = thr_ext > dz_ext;
	assign is_reverse = thr_ext < -dz_ext;
	assign thr_mag    = thr_q[THR_W-1] ? MAG_W'(-thr_q) : thr_q[MAG_W-1:0];
	assign rlim_ext   = (rev_limit_q == '0) ? CMP_W'(1) : CMP_W'(rev_limit_q);

	always_comb begin
		span = SPAN_W'(GAUGE_WIDTH);
		if (is_reverse && rlim_ext < CMP_W'(GAUGE_WIDTH)) begin
			span = SPAN_W'(rlim_ext);
		end
	end

	assign span_m1  = span - SPAN_W'(1);
	assign fill_num = PROD_W'(thr_mag) * PROD_W'(span_m1);

	logic             div_ge;
	logic [QUO_W-1:0] quo_next;

	assign div_ge   = (rem_q >= dsh_q);
	assign quo_next = {quo_q[QUO_W-2:0], div_ge};

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_level_q <= 1'b0;
			high_count_q <= '0;
			wait_count_q <= '0;
			last_thr_q   <= '0;
			phase_thr_q  <= 1'b0;
			step_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_take) begin
						prev_level_q <= sample.pin_level;
						if (pulse_done) begin
							high_count_q <= high_next;
							wait_count_q <= '0;
							state_q      <= S_MAP;
						end else if (timeout_hit) begin
							// A pulse still high is dropped and never reported.
							high_count_q <= '0;
							wait_count_q <= '0;
							state_q      <= S_WRITE;
						end else begin
							high_count_q <= high_next;
							wait_count_q <= wait_inc;
						end
					end
				end
				S_MAP: begin
					if (at_min || at_max) begin
						state_q <= S_GAUGE;
					end else begin
						phase_thr_q <= 1'b1;
						step_q      <= '0;
						state_q     <= S_DIVIDE;
					end
				end
				S_DIVIDE: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						state_q <= phase_thr_q ? S_GAUGE : S_WRITE;
					end
				end
				S_GAUGE: begin
					last_thr_q  <= thr_q;
					phase_thr_q <= 1'b0;
					step_q      <= '0;
					state_q     <= S_DIVIDE;
				end
				S_WRITE: begin
					if (!out_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the result and the divider datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				width_q <= high_count_q;
				if (sample_take && !pulse_done && timeout_hit) begin
					thr_q     <= '0;
					gear_q    <= GR_NEUTRAL;
					fill_q    <= '0;
					chg_q     <= 1'b0;
					present_q <= 1'b0;
				end
			end
			S_MAP: begin
				present_q <= 1'b1;
				if (at_min) begin
					thr_q <= -$signed(THR_OFFSET);
				end else if (at_max) begin
					thr_q <= $signed(THR_OFFSET);
				end
				rem_q <= thr_num;
				dsh_q <= NUM_W'({pulse_range, {(QUO_W-1){1'b0}}});
				quo_q <= '0;
			end
			S_DIVIDE: begin
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_next;
				if (step_q == STEP_LAST) begin
					if (phase_thr_q) begin
						thr_q <= $signed(quo_next - THR_OFFSET);
					end else begin
						fill_q <= quo_next[FILL_W-1:0];
					end
				end
			end
			S_GAUGE: begin
				if (is_drive) begin
					gear_q <= GR_FORWARD;
				end else if (is_reverse) begin
					gear_q <= GR_BACKWARD;
				end else begin
					gear_q <= GR_NEUTRAL;
				end
				chg_q <= (thr_q != last_thr_q);
				rem_q <= NUM_W'(fill_num);
				dsh_q <= FILL_DSH;
				quo_q <= '0;
			end
			S_WRITE: ;
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	logic out_load;

	assign out_load = (state_q == S_WRITE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_thr_q     <= thr_q;
			out_gear_q    <= gear_q;
			out_fill_q    <= fill_q;
			out_chg_q     <= chg_q;
			out_present_q <= present_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.throttle       = out_thr_q;
	assign result.gear           = out_gear_q;
	assign result.gauge_fill     = out_fill_q;
	assign result.changed        = out_chg_q;
	assign result.signal_present = out_present_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`RCPTD_ASSERT_NEXT(a_load_shows, out_load, result.valid, "loaded result not presented")
	`RCPTD_ASSERT_NEXT(a_thr_range,
		(state_q == S_DIVIDE) && (step_q == STEP_LAST) && phase_thr_q,
		($signed(thr_q) >= -8'sd100) && ($signed(thr_q) <= 8'sd99),
		"divided throttle out of range")
	`RCPTD_ASSERT_NOW(a_timeout_quiet, result.valid && !result.signal_present,
		(result.throttle == '0) && (result.gear == GR_NEUTRAL) && !result.changed,
		"timeout result carries a throttle")
	`RCPTD_ASSERT_NOW(a_drive_sign, result.valid && (result.gear == GR_FORWARD),
		!result.throttle[THR_W-1] && (result.throttle != '0),
		"drive gear with non-positive throttle")

endmodule

`default_nettype wire

>>> tb/sv/tb_rc_pulse_throttle_decoder_top.sv
// Self-checking testbench for rc_pulse_throttle_decoder_top: pin samples go in over the
// sample channel and decoded throttle results are checked against an in-bench predictor.
// Depends on rcptd_pkg, rcptd_in_if, rcptd_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_rc_pulse_throttle_decoder_top;
	import rcptd_pkg::*;

	// Full-scale throttle magnitude; the mapping runs from minus this to plus this.
	localparam int THR_FULL_SCALE = 100;
	// Margin after the last result, comfortably longer than a completed pulse keeps the block
	// busy, before the block can be assumed idle.
	localparam int SETTLE_CYCLES = 40;
	// Once every sample has gone in, results must follow within this many cycles.
	localparam int RESULT_WAIT_LIMIT = 5000;
	// Length of the deliberate receiver hold-off, in clock cycles.
	localparam int HOLD_CYCLES = 400;
	// Random samples offered per configuration phase.
	localparam int PHASE_SAMPLES = 100;

	// One decoded result, laid out as the result channel carries it.
	typedef struct packed {
		logic signed [THR_W-1:0] throttle;
		logic [GEAR_W-1:0]       gear;
		logic [FILL_W-1:0]       gauge_fill;
		logic                    changed;
		logic                    signal_present;
	} throttle_result_t;

	logic clk = 1'b0;
	logic arst_n;

	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	rcptd_in_if  sample_ch ();
	rcptd_out_if result_ch ();

	rc_pulse_throttle_decoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #6 clk = ~clk;

	// Pin samples waiting to be offered, and the results the predictor has worked out
	// for samples already taken by the block, oldest first.
	bit               pin_feed[$];
	throttle_result_t pending_results[$];

	// Set at a rising edge when a sample transfer took place there; the driver uses it
	// at the following falling edge to decide whether to move on to the next sample.
	bit in_fire = 1'b0;

	// Idle rates in percent for sender and receiver, and the receiver hold-off controls.
	int tx_idle_pct = 31;
	int rx_idle_pct = 31;
	bit rx_hold_req = 1'b0;
	bit rx_blocked  = 1'b0;

	int n_errors        = 0;
	int n_samples       = 0;
	int n_pulse_results = 0;
	int n_timeouts      = 0;
	int n_settings      = 0;

	// Predictor copy of the configuration registers.
	logic [COUNT_W-1:0] cfg_pulse_min;
	logic [COUNT_W-1:0] cfg_pulse_max;
	logic [DZ_W-1:0]    cfg_deadzone;
	logic [RLIM_W-1:0]  cfg_rev_limit;
	logic [COUNT_W-1:0] cfg_timeout;

	// Predictor copy of the decoder state: the pin one sample ago, the length of the
	// pulse being measured (zero when none is), the quiet count since the last result
	// and the last throttle reported with a signal present.
	bit                 pin_prev;
	logic [COUNT_W-1:0] pulse_len;
	logic [COUNT_W-1:0] quiet_len;
	int                 last_thr;

	task automatic report_mismatch(input string what, input int got, input int want);
		n_errors++;
		$display("[%0t] mismatch: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Clamp a pulse width to the configured limits and map it linearly onto the
	// throttle range. The lower limit is tested first, so with crossed limits a width
	// at or below pulse_min still gives full reverse; the division therefore only
	// ever runs with pulse_min strictly below pulse_max.
	function automatic int pulse_to_throttle(input int width);
		int lo;
		int hi;
		lo = cfg_pulse_min;
		hi = cfg_pulse_max;
		if (width <= lo)
			return -THR_FULL_SCALE;
		if (width >= hi)
			return THR_FULL_SCALE;
		return ((width - lo) * 2 * THR_FULL_SCALE) / (hi - lo) - THR_FULL_SCALE;
	endfunction

	// Derive gear and gauge position from a throttle value. In reverse the gauge span
	// comes from reverse_limit, with zero read as one and anything past the gauge
	// width read as the gauge width.
	function automatic throttle_result_t shape_result(input int thr, input bit chg,
		input bit present);
		throttle_result_t r;
		int dz;
		int mag;
		int span;
		dz = cfg_deadzone;
		r.gear = GR_NEUTRAL;
		if (thr > dz)
			r.gear = GR_FORWARD;
		else if (thr < -dz)
			r.gear = GR_BACKWARD;
		mag = (thr < 0) ? -thr : thr;
		span = GAUGE_WIDTH_DEF;
		if (r.gear == GR_BACKWARD) begin
			span = cfg_rev_limit;
			if (span < 1)
				span = 1;
			if (span > GAUGE_WIDTH_DEF)
				span = GAUGE_WIDTH_DEF;
		end
		r.throttle       = THR_W'(thr);
		r.gauge_fill     = FILL_W'((mag * (span - 1)) / THR_FULL_SCALE);
		r.changed        = chg;
		r.signal_present = present;
		return r;
	endfunction

	// Advance the predictor by one pin sample. Returns 1 when the sample produces a
	// result, which is then placed in r.
	function automatic bit decode_tick(input bit level, output throttle_result_t r);
		bit done;
		int width;
		int thr;
		done  = 1'b0;
		width = 0;
		r     = '0;
		if (level) begin
			if (!pin_prev)
				pulse_len = COUNT_W'(1);
			else if (pulse_len != 0 && pulse_len != COUNT_MAX)
				pulse_len++;
		end else if (pin_prev && pulse_len != 0) begin
			done      = 1'b1;
			width     = pulse_len;
			pulse_len = '0;
		end
		pin_prev = level;

		if (done) begin
			thr       = pulse_to_throttle(width);
			r         = shape_result(thr, thr != last_thr, 1'b1);
			last_thr  = thr;
			quiet_len = '0;
			return 1'b1;
		end

		// A register value of zero behaves as one: every quiet sample times out.
		if (quiet_len != COUNT_MAX)
			quiet_len++;
		if (quiet_len >= cfg_timeout) begin
			quiet_len = '0;
			pulse_len = '0;
			r = shape_result(0, 1'b0, 1'b0);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [PDATA_W-1:0] setting_value(input reg_idx_t idx);
		case (idx)
			REG_PULSE_MIN: return PDATA_W'(cfg_pulse_min);
			REG_PULSE_MAX: return PDATA_W'(cfg_pulse_max);
			REG_DEADZONE:  return PDATA_W'(cfg_deadzone);
			REG_REV_LIMIT: return PDATA_W'(cfg_rev_limit);
			REG_TIMEOUT:   return PDATA_W'(cfg_timeout);
			default:       return '0;
		endcase
	endfunction

	// One APB transfer: a setup cycle, then an access cycle that completes at the next
	// rising edge. Read data is taken at that edge, before any update it triggers.
	task automatic apb_access(input bit wr, input reg_idx_t idx, input logic [PDATA_W-1:0] wdata,
		output logic [PDATA_W-1:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = {idx, 2'b00};
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic check_setting(input reg_idx_t idx);
		logic [PDATA_W-1:0] rd;
		apb_access(1'b0, idx, '0, rd);
		if (rd !== setting_value(idx))
			report_mismatch($sformatf("readback of %s", idx.name()), rd, setting_value(idx));
	endtask

	task automatic write_setting(input reg_idx_t idx, input int unsigned val);
		logic [PDATA_W-1:0] rd;
		apb_access(1'b1, idx, PDATA_W'(val), rd);
		case (idx)
			REG_PULSE_MIN: cfg_pulse_min = COUNT_W'(val);
			REG_PULSE_MAX: cfg_pulse_max = COUNT_W'(val);
			REG_DEADZONE:  cfg_deadzone  = DZ_W'(val);
			REG_REV_LIMIT: cfg_rev_limit = RLIM_W'(val);
			REG_TIMEOUT:   cfg_timeout   = COUNT_W'(val);
			default: ;
		endcase
		check_setting(idx);
	endtask

	// Wait for the sender to run dry and every predicted result to be delivered, then
	// give the block time to finish anything that produces no result.
	task automatic settle();
		int waited;
		while (pin_feed.size() != 0 || sample_ch.valid)
			@(posedge clk);
		waited = 0;
		while (pending_results.size() != 0 && waited < RESULT_WAIT_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			report_mismatch("results never delivered", pending_results.size(), 0);
			pending_results.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input int unsigned pmin, input int unsigned pmax,
		input int unsigned dz, input int unsigned rlim, input int unsigned tmo);
		settle();
		write_setting(REG_PULSE_MIN, pmin);
		write_setting(REG_PULSE_MAX, pmax);
		write_setting(REG_DEADZONE, dz);
		write_setting(REG_REV_LIMIT, rlim);
		write_setting(REG_TIMEOUT, tmo);
		n_settings++;
	endtask

	task automatic push_run(input bit level, input int n);
		repeat (n) pin_feed.push_back(level);
	endtask

	// Random traffic shaped for the current configuration, or noise only if noise_only.
	// Otherwise most is well-formed pulses whose widths straddle limits of up to 300;
	// the rest is pin noise, quiet stretches that time out (if the timeout is up to 400)
	// and pulses held high past such a timeout so that they are abandoned.
	task automatic queue_random_traffic(input int n_items, input bit noise_only);
		int added;
		int lo;
		int hi;
		int kind;
		int n;
		int tmo_span;
		added = 0;
		lo = (cfg_pulse_min < cfg_pulse_max) ? cfg_pulse_min : cfg_pulse_max;
		hi = (cfg_pulse_min < cfg_pulse_max) ? cfg_pulse_max : cfg_pulse_min;
		if (hi > 300)
			hi = 300;
		if (lo > hi)
			lo = hi;
		tmo_span = (cfg_timeout > 400) ? 50 : int'(cfg_timeout);
		while (added < n_items) begin
			kind = $urandom_range(99);
			if (noise_only || kind < 12) begin
				n = $urandom_range(1, 12);
				repeat (n) pin_feed.push_back(1'($urandom_range(1)));
				added += n;
			end else if (kind < 82) begin
				n = $urandom_range(1, 6);
				push_run(1'b0, n);
				added += n;
				n = $urandom_range((lo > 3) ? lo - 3 : 1, hi + 3);
				push_run(1'b1, n);
				added += n;
			end else if (kind < 92) begin
				n = tmo_span + $urandom_range(0, 8);
				push_run(1'b0, n);
				added += n;
			end else begin
				n = tmo_span + $urandom_range(0, 5);
				push_run(1'b1, n);
				push_run(1'b0, 1);
				added += n + 1;
			end
		end
	endtask

	// Sample driver: offers the next queued pin sample at the falling edge, holds it
	// until the transfer completes, and idles at random between samples.
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (!sample_ch.valid || in_fire) begin
			if (pin_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				sample_ch.valid     <= 1'b1;
				sample_ch.pin_level <= pin_feed.pop_front();
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: stalls at random, and takes nothing while a hold-off is running.
	always @(negedge clk) begin
		result_ch.ready <= !rx_blocked && ($urandom_range(99) >= rx_idle_pct);
	end

	// Hold-off: once asked for, the receiver refuses results for HOLD_CYCLES while
	// the sender keeps going, so the output register fills and the block stalls its
	// sample channel.
	initial begin : receiver_hold
		wait (rx_hold_req);
		@(posedge clk);
		rx_blocked = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_blocked = 1'b0;
	end

	// Monitor: checks each result transfer against the oldest prediction, then feeds
	// each sample transfer into the predictor.
	always @(posedge clk) begin : monitor
		throttle_result_t got;
		throttle_result_t want;
		throttle_result_t predicted;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= sample_ch.valid && sample_ch.ready;

			if (result_ch.valid && result_ch.ready) begin
				got.throttle       = result_ch.throttle;
				got.gear           = result_ch.gear;
				got.gauge_fill     = result_ch.gauge_fill;
				got.changed        = result_ch.changed;
				got.signal_present = result_ch.signal_present;
				if (got.signal_present)
					n_pulse_results++;
				else
					n_timeouts++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending, throttle", got.throttle, 0);
				end else begin
					want = pending_results.pop_front();
					if (got.throttle !== want.throttle)
						report_mismatch("throttle", got.throttle, want.throttle);
					if (got.gear !== want.gear)
						report_mismatch("gear", got.gear, want.gear);
					if (got.gauge_fill !== want.gauge_fill)
						report_mismatch("gauge_fill", got.gauge_fill, want.gauge_fill);
					if (got.changed !== want.changed)
						report_mismatch("changed", got.changed, want.changed);
					if (got.signal_present !== want.signal_present)
						report_mismatch("signal_present", got.signal_present,
							want.signal_present);
				end
			end

			if (sample_ch.valid && sample_ch.ready) begin
				n_samples++;
				if (decode_tick(sample_ch.pin_level, predicted))
					pending_results.push_back(predicted);
			end
		end
	end

	// Watchdog: far beyond the slowest legal run, even with every pulse stalled.
	initial begin : watchdog
		#30ms;
		$display("[%0t] run did not complete in time", $time);
		$display("tb_rc_pulse_throttle_decoder_top: FAIL");
		$finish;
	end

	initial begin : stimulus
		// Every block input has a defined level from time zero.
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.pin_level = 1'b0;
		result_ch.ready     = 1'b0;

		// Predictor starts from the reset defaults with all counters clear.
		cfg_pulse_min = PULSE_MIN_RST;
		cfg_pulse_max = PULSE_MAX_RST;
		cfg_deadzone  = DEADZONE_RST;
		cfg_rev_limit = REV_LIMIT_RST;
		cfg_timeout   = TIMEOUT_RST;
		pin_prev      = 1'b0;
		pulse_len     = '0;
		quiet_len     = '0;
		last_thr      = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The registers must read back their reset defaults.
		for (int i = REG_PULSE_MIN; i <= REG_TIMEOUT; i++)
			check_setting(reg_idx_t'(i));

		// A pin already high on the very first sample counts as a rising edge. With the
		// default limits this short pulse lands at full reverse on the full gauge span.
		push_run(1'b1, 3);
		push_run(1'b0, 2);

		// Tight limits so that every mapping point is only a few samples wide: full
		// forward, full reverse with a zero reverse limit read as one, exact neutral
		// with no deadzone, an unchanged repeat, then a pulse held past the timeout
		// (abandoned, so its falling edge reports nothing) and a quiet timeout.
		set_config(1, 5, 0, 0, 8);
		push_run(1'b0, 1); push_run(1'b1, 5);
		push_run(1'b0, 1); push_run(1'b1, 1);
		push_run(1'b0, 1); push_run(1'b1, 3);
		push_run(1'b0, 1); push_run(1'b1, 4);
		push_run(1'b0, 1); push_run(1'b1, 4);
		push_run(1'b0, 1); push_run(1'b1, 2);
		push_run(1'b0, 1); push_run(1'b1, 9);
		push_run(1'b0, 9);

		// Crossed limits: the lower limit wins at or below it, anything above goes to
		// full forward. A reverse limit beyond the gauge width is read as the width.
		set_config(6, 3, 99, 127, 20);
		push_run(1'b1, 2); push_run(1'b0, 1);
		push_run(1'b1, 7); push_run(1'b0, 1);
		push_run(1'b1, 4); push_run(1'b0, 1);

		// Timeout register at zero: every sample without a completed pulse times out.
		set_config(6, 3, 100, 127, 0);
		push_run(1'b1, 2); push_run(1'b0, 2); push_run(1'b1, 1); push_run(1'b0, 1);

		// Longer pulses: one at each limit, one between them, one past the upper limit,
		// then a full quiet stretch that reaches the timeout.
		set_config(40, 100, 100, 96, 120);
		push_run(1'b0, 2); push_run(1'b1, 40);
		push_run(1'b0, 2); push_run(1'b1, 75);
		push_run(1'b0, 2); push_run(1'b1, 100);
		push_run(1'b0, 2); push_run(1'b1, 110);
		push_run(1'b0, 121);
		push_run(1'b1, 2); push_run(1'b0, 1);

		// Random phases. The first includes the receiver hold-off, opened by a burst of
		// short pulses so that results pile up, and, halfway, the sender waits until
		// every predicted result has been delivered.
		set_config(10, 50, 10, 96, 120);
		rx_hold_req = 1'b1;
		repeat (4) begin
			push_run(1'b0, 1);
			push_run(1'b1, 5);
		end
		queue_random_traffic(PHASE_SAMPLES / 2, 1'b0);
		settle();
		queue_random_traffic(PHASE_SAMPLES / 2, 1'b0);

		// Equal limits, no deadzone, smallest reverse span, and no idling on either
		// side for the whole phase.
		set_config(20, 20, 0, 1, 60);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_random_traffic(PHASE_SAMPLES, 1'b0);
		settle();
		tx_idle_pct = 31;
		rx_idle_pct = 31;

		set_config(40, 12, 100, 127, 80);
		queue_random_traffic(PHASE_SAMPLES, 1'b0);

		set_config(0, 64, 50, 0, 200);
		queue_random_traffic(PHASE_SAMPLES, 1'b0);

		// Highest limits with a timeout of one: every sample times out, so only noise.
		set_config(30000, 30000, 100, 1, 1);
		queue_random_traffic(PHASE_SAMPLES / 2, 1'b1);

		settle();

		$display("covered %0d pin samples over %0d register settings plus the defaults,",
			n_samples, n_settings);
		$display("giving %0d measured-pulse results and %0d timeout results",
			n_pulse_results, n_timeouts);
		if (n_errors == 0)
			$display("tb_rc_pulse_throttle_decoder_top: PASS");
		else
			$display("tb_rc_pulse_throttle_decoder_top: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rcptd_pkg.sv
rtl/rcptd_in_if.sv
rtl/rcptd_out_if.sv
rtl/rc_pulse_throttle_decoder_top.sv
tb/sv/tb_rc_pulse_throttle_decoder_top.sv
